>>> src/btt_pkg.sv
package btt_pkg;

  localparam logic [7:0] CH_BLANK   = 8'd32;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_NEWLINE = 8'd10;

  localparam int         CNT_W       = 5;
  localparam logic [4:0] PENDING_MAX = 5'd31;

  localparam int          MASK_W     = 32;
  localparam logic [31:0] MASK_RESET = 32'h8080_8080;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // One queued run: tabs, then blanks, then the character itself
  typedef struct packed {
    logic [CNT_W-1:0] tabs;
    logic [CNT_W-1:0] blanks;
    logic [7:0]       ch;
  } cmd_t;

endpackage

>>> src/btt_front.sv
module btt_front #(
  parameter int LINE_POSITIONS = 32,
  localparam int COL_W = $clog2(LINE_POSITIONS + 2)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [btt_pkg::MASK_W-1:0] mask,
  input  logic                      in_valid,
  input  logic [7:0]                text_byte,
  output logic                      in_ready,
  input  logic                      q_full,
  output logic                      push,
  output btt_pkg::cmd_t             push_cmd
);

  localparam logic [COL_W-1:0] COL_FIRST = COL_W'(1);
  localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(LINE_POSITIONS + 1);

  logic [COL_W-1:0]          column;
  logic [btt_pkg::CNT_W-1:0] pending_tabs;
  logic [btt_pkg::CNT_W-1:0] pending_blanks;
  logic                      seeking;

  logic [COL_W-1:0] col_next;
  logic [5:0]       col_ext;
  logic [4:0]       mask_idx;
  logic             at_stop;
  logic             accept;
  logic             is_blank;

  assign col_ext  = 6'(column);
  assign mask_idx = 5'(col_ext - 6'd1);
  assign at_stop  = (column > COL_W'(LINE_POSITIONS)) || (column == '0) || mask[mask_idx];
  assign col_next = (column >= COL_LIMIT) ? COL_LIMIT : column + COL_FIRST;

  assign in_ready = !seeking && !q_full;
  assign accept   = in_valid && in_ready;
  assign is_blank = (text_byte == btt_pkg::CH_BLANK);

  assign push            = accept && !is_blank;
  assign push_cmd.tabs   = pending_tabs;
  assign push_cmd.blanks = (text_byte == btt_pkg::CH_TAB) ? '0 : pending_blanks;
  assign push_cmd.ch     = text_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      column         <= COL_FIRST;
      pending_tabs   <= '0;
      pending_blanks <= '0;
      seeking        <= 1'b0;
    end else if (seeking) begin
      // walk one column a cycle until the move off a stop
      column <= col_next;
      if (at_stop) begin
        seeking <= 1'b0;
      end
    end else if (accept) begin
      if (is_blank) begin
        if (at_stop) begin
          pending_blanks <= '0;
          if (pending_tabs != btt_pkg::PENDING_MAX) begin
            pending_tabs <= pending_tabs + 1'b1;
          end
        end else if (pending_blanks != btt_pkg::PENDING_MAX) begin
          pending_blanks <= pending_blanks + 1'b1;
        end
        column <= col_next;
      end else begin
        pending_tabs   <= '0;
        pending_blanks <= '0;
        if (text_byte == btt_pkg::CH_NEWLINE) begin
          column <= COL_FIRST;
        end else if (text_byte == btt_pkg::CH_TAB) begin
          seeking <= 1'b1;
        end else begin
          column <= col_next;
        end
      end
    end
  end

endmodule

>>> src/btt_queue.sv
module btt_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  btt_pkg::cmd_t push_cmd,
  input  logic          pop,
  output btt_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);

  btt_pkg::cmd_t                 mem [btt_pkg::QUEUE_DEPTH];
  logic [btt_pkg::QPTR_W-1:0]    wr_ptr;
  logic [btt_pkg::QPTR_W-1:0]    rd_ptr;
  logic [btt_pkg::QPTR_W:0]      count;

  assign full  = (count == (btt_pkg::QPTR_W + 1)'(btt_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> src/btt_back.sv
module btt_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  btt_pkg::cmd_t q_head,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          run_last
);

  logic                      busy;
  logic [btt_pkg::CNT_W-1:0] tabs_left;
  logic [btt_pkg::CNT_W-1:0] blanks_left;
  logic [7:0]                ch;

  logic done;
  logic load;

  assign run_last  = (tabs_left == '0) && (blanks_left == '0);
  assign out_valid = busy;
  assign out_byte  = (tabs_left != '0)   ? btt_pkg::CH_TAB :
                     (blanks_left != '0) ? btt_pkg::CH_BLANK : ch;

  assign done  = busy && out_ready && run_last;
  assign load  = !q_empty && (!busy || done);
  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tabs_left   <= q_head.tabs;
      blanks_left <= q_head.blanks;
      ch          <= q_head.ch;
    end else if (busy && out_ready) begin
      // drain tabs first, then blanks
      if (tabs_left != '0) begin
        tabs_left <= tabs_left - 1'b1;
      end else if (blanks_left != '0) begin
        blanks_left <= blanks_left - 1'b1;
      end
    end
  end

endmodule

>>> src/blank_run_to_tab_converter.sv
// Blank-run to tab converter. Text bytes enter one per transaction; blanks are
// held back and replaced by tabs where they reach a tab stop. Any other byte
// releases a run of pending tabs, then pending blanks (dropped before a tab),
// then the byte itself, flagged with run_last. Tab stops come from the
// tab_stop_mask register at address 0 (bit i marks column i+1; reset every
// eighth column); columns beyond LINE_POSITIONS are always stops. Write it only
// while the block is idle. Any byte is taken while the queue has room and no
// tab walk is under way; a tab then holds the input off as the column walks
// one position a cycle to the next stop and one column past it. A four-entry
// queue sits between input and output; the output side emits one result a
// cycle while out_ready is high; a byte that releases n pending characters
// yields n+1 results, and these set the sustained rate once the queue fills.
module blank_run_to_tab_converter #(
  parameter int LINE_POSITIONS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        run_last
);

  logic [btt_pkg::MASK_W-1:0] tab_stop_mask;
  logic                       q_full;
  logic                       q_empty;
  logic                       push;
  logic                       pop;
  btt_pkg::cmd_t              push_cmd;
  btt_pkg::cmd_t              q_head;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? '0 : tab_stop_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      tab_stop_mask <= btt_pkg::MASK_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      tab_stop_mask <= pwdata;
    end
  end

  btt_front #(
    .LINE_POSITIONS(LINE_POSITIONS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .mask     (tab_stop_mask),
    .in_valid (in_valid),
    .text_byte(text_byte),
    .in_ready (in_ready),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  btt_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (q_head),
    .full    (q_full),
    .empty   (q_empty)
  );

  btt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .run_last (run_last)
  );

endmodule

>>> tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          LINE_POS      = 32;
  localparam logic [5:0]  COL_LIMIT     = 6'(LINE_POS + 1);
  localparam logic [2:0]  ADDR_TAB_STOP_MASK = 3'd0;
  localparam logic [2:0]  ADDR_UNMAPPED      = 3'd4;
  localparam int          CYCLE_LIMIT   = 500000;
  localparam int          SETTLE_CYCLES = 48;
  localparam int          LONG_HOLD     = 300;
  localparam int          PHASE_ITEMS   = 60;
  localparam int          N_DIRECTED    = 25;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_result_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       typed;
    logic [4:0] tabs;
    logic [4:0] blanks;
  } text_row_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  text_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        run_last;

  // predictor state
  logic [31:0] tab_mask    = btt_pkg::MASK_RESET;
  logic [5:0]  col_pos     = 6'd1;
  logic [4:0]  held_tabs   = '0;
  logic [4:0]  held_blanks = '0;

  text_result_t expected_chars[$];
  text_result_t step_chars[$];
  logic [7:0]   line_bytes[$];
  text_row_t    directed_rows[0:N_DIRECTED-1];

  int mismatches    = 0;
  int cycle_count   = 0;
  int burst_left    = 1;
  int hold_requests = 0;
  int holds_granted = 0;
  int hold_left     = 0;
  int stall_slot    = 0;
  logic [15:0] stall_pattern = '0;

  blank_run_to_tab_converter #(.LINE_POSITIONS(LINE_POS)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .text_byte (text_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .run_last  (run_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic stop_at(logic [5:0] c);
    if (c > LINE_POS || c == 6'd0) return 1'b1;
    return tab_mask[c - 6'd1];
  endfunction

  function automatic logic [5:0] advance_col(logic [5:0] c);
    return (c >= COL_LIMIT) ? COL_LIMIT : c + 6'd1;
  endfunction

  // Work out what one text byte releases, into step_chars, and move the state on.
  task automatic entab_step(input logic [7:0] ch);
    step_chars.delete();
    if (ch == btt_pkg::CH_BLANK) begin
      if (stop_at(col_pos)) begin
        held_blanks = '0;
        if (held_tabs < btt_pkg::PENDING_MAX) held_tabs++;
      end else if (held_blanks < btt_pkg::PENDING_MAX) begin
        held_blanks++;
      end
      col_pos = advance_col(col_pos);
    end else begin
      repeat (held_tabs) step_chars.push_back('{btt_pkg::CH_TAB, 1'b0});
      held_tabs = '0;
      if (ch != btt_pkg::CH_TAB) begin
        repeat (held_blanks) step_chars.push_back('{btt_pkg::CH_BLANK, 1'b0});
      end
      held_blanks = '0;
      step_chars.push_back('{ch, 1'b1});
      if (ch == btt_pkg::CH_NEWLINE) begin
        col_pos = 6'd1;
      end else begin
        if (ch == btt_pkg::CH_TAB) begin
          while (!stop_at(col_pos)) col_pos = advance_col(col_pos);
        end
        col_pos = advance_col(col_pos);
      end
    end
  endtask

  // Offer one byte, hold it until the transaction, then record what it should release.
  task automatic send_byte(input logic [7:0] ch, input text_row_t row);
    int gap;
    @(negedge clk);
    in_valid  <= 1'b1;
    text_byte <= ch;
    do @(posedge clk); while (!in_ready);
    entab_step(ch);
    if (row.typed) begin
      repeat (row.tabs) expected_chars.push_back('{btt_pkg::CH_TAB, 1'b0});
      repeat (row.blanks) expected_chars.push_back('{btt_pkg::CH_BLANK, 1'b0});
      expected_chars.push_back('{ch, 1'b1});
    end else begin
      foreach (step_chars[i]) expected_chars.push_back(step_chars[i]);
    end
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 4);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_mask_readback();
    logic [31:0] got;
    apb_access(1'b0, ADDR_TAB_STOP_MASK, '0, got);
    if (got !== tab_mask) begin
      $error("tab_stop_mask readback: expected %08h, got %08h", tab_mask, got);
      mismatches++;
    end
  endtask

  task automatic drain_and_settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One line of text: words, blank runs (now and then long ones), tabs and stray bytes.
  task automatic compose_line();
    int pieces;
    int kind;
    int n;
    line_bytes.delete();
    pieces = $urandom_range(1, 6);
    repeat (pieces) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        n = $urandom_range(1, 7);
        repeat (n) line_bytes.push_back(8'($urandom_range(33, 126)));
      end else if (kind < 8) begin
        n = ($urandom_range(0, 6) == 0) ? $urandom_range(20, 45) : $urandom_range(1, 9);
        repeat (n) line_bytes.push_back(btt_pkg::CH_BLANK);
      end else if (kind == 8) begin
        line_bytes.push_back(btt_pkg::CH_TAB);
      end else begin
        line_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 9) != 0) line_bytes.push_back(btt_pkg::CH_NEWLINE);
  endtask

  task automatic run_random_text(input int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      compose_line();
      foreach (line_bytes[i]) begin
        if (sent < count) begin
          send_byte(line_bytes[i], '0);
          sent++;
        end
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    text_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        $error("result with nothing expected: out_byte %02h run_last %0b", out_byte, run_last);
        mismatches++;
      end else begin
        want = expected_chars.pop_front();
        if (out_byte !== want.ch) begin
          $error("out_byte: expected %02h, got %02h", want.ch, out_byte);
          mismatches++;
        end
        if (run_last !== want.last) begin
          $error("run_last: expected %0b, got %0b", want.last, run_last);
          mismatches++;
        end
      end
    end
  end

  // Receiver: stall on a random 16-bit pattern, or hold off for a long stretch on request.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (holds_granted != hold_requests) begin
      holds_granted++;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      if (stall_slot == 0) begin
        stall_slot = 15;
        case ($urandom_range(0, 3))
          0: stall_pattern = '0;
          1: stall_pattern = 16'($urandom);
          2: stall_pattern = 16'($urandom & $urandom);
          default: stall_pattern = 16'($urandom | $urandom);
        endcase
      end else begin
        stall_slot--;
      end
      out_ready <= !stall_pattern[stall_slot];
    end
  end

  initial begin : stimulus
    logic [31:0] mask;
    logic [31:0] unused;
    directed_rows = '{
      '{8'h41,               1'b1, 5'd0, 5'd0},
      '{8'h00,               1'b1, 5'd0, 5'd0},
      '{8'hFF,               1'b1, 5'd0, 5'd0},
      '{btt_pkg::CH_BLANK,   1'b0, 5'd0, 5'd0},
      '{btt_pkg::CH_BLANK,   1'b0, 5'd0, 5'd0},
      '{8'h78,               1'b1, 5'd0, 5'd2},
      '{btt_pkg::CH_BLANK,   1'b0, 5'd0, 5'd0},
      '{btt_pkg::CH_BLANK,   1'b0, 5'd0, 5'd0},
      '{8'h79,               1'b1, 5'd1, 5'd0},
      '{btt_pkg::CH_BLANK,   1'b0, 5'd0, 5'd0},
      '{btt_pkg::CH_TAB,     1'b1, 5'd0, 5'd0},
      '{btt_pkg::CH_NEWLINE, 1'b1, 5'd0, 5'd0},
      '{btt_pkg::CH_TAB,     1'b1, 5'd0, 5'd0},
      '{btt_pkg::CH_TAB,     1'b1, 5'd0, 5'd0},
      '{btt_pkg::CH_TAB,     1'b1, 5'd0, 5'd0},
      '{btt_pkg::CH_TAB,     1'b1, 5'd0, 5'd0},
      '{btt_pkg::CH_BLANK,   1'b0, 5'd0, 5'd0},
      '{btt_pkg::CH_BLANK,   1'b0, 5'd0, 5'd0},
      '{btt_pkg::CH_TAB,     1'b1, 5'd2, 5'd0},
      '{8'h42,               1'b1, 5'd0, 5'd0},
      '{btt_pkg::CH_BLANK,   1'b0, 5'd0, 5'd0},
      '{8'h43,               1'b1, 5'd1, 5'd0},
      '{btt_pkg::CH_NEWLINE, 1'b1, 5'd0, 5'd0},
      '{8'h7F,               1'b0, 5'd0, 5'd0},
      '{8'h80,               1'b0, 5'd0, 5'd0}
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    check_mask_readback();
    foreach (directed_rows[i]) send_byte(directed_rows[i].ch, directed_rows[i]);
    drain_and_settle();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: mask = 32'h0000_0000;
        1: mask = 32'hFFFF_FFFF;
        2: mask = $urandom;
        3: mask = $urandom & $urandom & $urandom;
        4: mask = $urandom | $urandom;
        default: mask = btt_pkg::MASK_RESET;
      endcase
      apb_access(1'b1, ADDR_TAB_STOP_MASK, mask, unused);
      tab_mask = mask;
      if (phase == 1) begin
        // a write past the last register must leave the mask alone
        apb_access(1'b1, ADDR_UNMAPPED, $urandom, unused);
        check_mask_readback();
      end
      if (phase == 2) hold_requests++;
      run_random_text(PHASE_ITEMS);
      drain_and_settle();
    end

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
